// ----- sv/cdw_pkg.sv -----
// Shared constants, types and the arctangent table of the concentric disk warp.
package cdw_pkg;

    // Fixed-point setup
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int EXT_W         = 16;
    localparam int RAD_W         = 16;
    localparam int OUT_W         = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int ATAN_ENTRIES  = 24;
    localparam int STG_W         = 5;

    // Derived widths
    localparam int MAG_W       = FRAC_BITS + 1;
    localparam int N_W         = FRAC_BITS + 2;
    localparam int DEN_W       = (EXT_W > MAG_W) ? EXT_W : MAG_W;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int NORM_STEPS  = FRAC_BITS + 1;
    localparam int RATIO_STEPS = FRAC_BITS;
    localparam int ANG_W       = 32;
    localparam int CW          = 33;
    localparam int R_W         = 18;
    localparam int TH_W        = 30;
    localparam int PT_W        = TH_W + MAG_W;
    localparam int PR_W        = N_W + RAD_W + 1;
    localparam int PO_W        = R_W + CW;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Constants: the first two in Q30
    localparam logic [TH_W-1:0] PI4_Q30      = TH_W'(843314857);
    localparam logic [CW-1:0]   GAIN_INV_Q30 = CW'(652032874);
    localparam int              OUT_MAX      = 65535;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_EXTENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B_EXTENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

    // One restoring-division step operand set.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quot;
    } t_div;

    // One CORDIC rotation operand set.
    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] z;
    } t_cor;

    // Arctangent of 2^-idx in Q30 radians.
    function automatic logic [ANG_W-1:0] cdw_atan(input logic [STG_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd843314857;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043837;
            5'd3:    v = 32'd133525159;
            5'd4:    v = 32'd67021687;
            5'd5:    v = 32'd33543516;
            5'd6:    v = 32'd16775851;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194283;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048576;
            5'd11:   v = 32'd524288;
            5'd12:   v = 32'd262144;
            5'd13:   v = 32'd131072;
            5'd14:   v = 32'd65536;
            5'd15:   v = 32'd32768;
            5'd16:   v = 32'd16384;
            5'd17:   v = 32'd8192;
            5'd18:   v = 32'd4096;
            5'd19:   v = 32'd2048;
            5'd20:   v = 32'd1024;
            5'd21:   v = 32'd512;
            5'd22:   v = 32'd256;
            5'd23:   v = 32'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/concentric_disk_warp_top.sv -----
// Top level of the concentric square-to-disk warp pipeline.
//
// Usage: sample points (u, v) arrive on the slave stream, tdata holding u in
// bits 15:0 and v in bits 31:16, tlast marking the final sample of a batch.
// Each point gives one disk point on the master stream: x in bits 16:0 and
// y in bits 33:17 as signed Q8.8, tlast copied from the input.
// The configuration port writes the rectangle width (index 0), height
// (index 1) and radius in Q8.8 (index 2); writes go in while no sample is
// in flight, which the user must see to, the block does not enforce it. Other indexes are ignored.
// Throughput is one point per cycle unless the receiver stalls. From the
// input transfer a point passes 17 normalization divider cells, three
// setup stages, 16 ratio divider cells, two angle and radius stages,
// 16 CORDIC cells and one multiply stage ahead of the output register.
// All stages advance together; when the receiver stalls with a result
// waiting, the whole pipeline holds and tready drops.
// Reset clears every valid bit and loads the registers with width and
// height 65535 and radius 1.0.
module concentric_disk_warp_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cdw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cdw_pkg::EXT_W-1:0]         i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // u_coord [15:0], v_coord [31:16]
    input  logic [cdw_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // x_out [16:0], y_out [33:17], zero fill above
    output logic [cdw_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);
    import cdw_pkg::*;

    typedef struct packed {
        logic valid;
        logic last;
        logic sat_u;
        logic sat_v;
    } t_sb_a;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic signed [N_W-1:0] lead;
        logic                  neg;
        logic                  major;
        logic                  zero;
    } t_sb_b;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic signed [R_W-1:0] r;
        logic                  major;
        logic                  zero;
    } t_sb_c;

    logic                      w_en;
    logic [EXT_W-1:0]          r_a_ext;
    logic [EXT_W-1:0]          r_b_ext;
    logic [RAD_W-1:0]          r_radius;
    logic [DEN_W-1:0]          w_ea;
    logic [DEN_W-1:0]          w_eb;
    logic [EXT_W-1:0]          w_u;
    logic [EXT_W-1:0]          w_v;

    t_div                      w_nu [0:NORM_STEPS];
    t_div                      w_nv [0:NORM_STEPS];
    t_sb_a                     r_sba [0:NORM_STEPS-1];

    logic                      r_s1_valid, r_s1_last;
    logic signed [N_W-1:0]     r_s1_xn, r_s1_yn;
    logic signed [N_W-1:0]     n_s1_xn, n_s1_yn;

    logic                      r_s2_valid, r_s2_last, r_s2_neg, r_s2_zero;
    logic signed [N_W-1:0]     r_s2_xn, r_s2_yn;
    logic [MAG_W-1:0]          r_s2_ax, r_s2_ay;

    t_sb_b                     r_s3_sb;
    t_div                      r_s3_div;
    t_sb_b                     n_s3_sb;
    t_div                      n_s3_div;
    logic [MAG_W-1:0]          w_num, w_den;

    t_div                      w_rt [0:RATIO_STEPS];
    t_sb_b                     r_sbb [0:RATIO_STEPS-1];

    t_sb_b                     r_t1_sb;
    logic [PT_W-1:0]           r_t1_pth;
    logic signed [PR_W-1:0]    r_t1_pr;
    logic signed [PR_W-1:0]    w_rs;
    logic signed [ANG_W-1:0]   w_mag;

    t_cor                      w_cor [0:CORDIC_STAGES];
    t_sb_c                     r_sbc [0:CORDIC_STAGES];

    logic                      r_m1_valid, r_m1_last, r_m1_zero;
    logic signed [PO_W-1:0]    r_m1_px, r_m1_py;
    logic signed [CW-1:0]      w_tx, w_ty;

    logic                      r_o_valid, r_o_last;
    logic signed [OUT_W-1:0]   r_o_x, r_o_y;
    logic signed [OUT_W-1:0]   n_o_x, n_o_y;

    // Round half up from Q30 and saturate to the output range.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PO_W-1:0] p);
        logic signed [PO_W-1:0]    s;
        logic signed [PO_W-31:0]   v;
        logic signed [OUT_W-1:0]   o;
        s = p + (PO_W'(1) <<< 29);
        v = s[PO_W-1:30];
        if (v > (PO_W-30)'(OUT_MAX)) begin
            o = OUT_W'(OUT_MAX);
        end else if (v < -(PO_W-30)'(OUT_MAX)) begin
            o = -OUT_W'(OUT_MAX);
        end else begin
            o = v[OUT_W-1:0];
        end
        return o;
    endfunction

    // All stages move together unless a finished result is held.
    assign w_en            = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ext  <= EXT_W'(65535);
            r_b_ext  <= EXT_W'(65535);
            r_radius <= RAD_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_A_EXTENT: r_a_ext  <= i_cfg_data;
                CFG_B_EXTENT: r_b_ext  <= i_cfg_data;
                CFG_RADIUS:   r_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero extent acts as an extent of one.
    assign w_ea = (r_a_ext == '0) ? DEN_W'(1) : DEN_W'(r_a_ext);
    assign w_eb = (r_b_ext == '0) ? DEN_W'(1) : DEN_W'(r_b_ext);
    assign w_u  = i_s_axis_tdata[EXT_W-1:0];
    assign w_v  = i_s_axis_tdata[2*EXT_W-1:EXT_W];

    // Normalization dividers: coordinate * 2^(F+1) / extent, one bit per cell.
    assign w_nu[0] = '{rem: DEN_W'(w_u), den: w_ea, quot: '0};
    assign w_nv[0] = '{rem: DEN_W'(w_v), den: w_eb, quot: '0};

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        cdw_div_cell u_cell_u (.i_clk(i_clk), .i_en(w_en), .i_d(w_nu[k]), .o_d(w_nu[k+1]));
        cdw_div_cell u_cell_v (.i_clk(i_clk), .i_en(w_en), .i_d(w_nv[k]), .o_d(w_nv[k+1]));
    end

    // Sideband that travels beside the normalization cells.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NORM_STEPS; k++) begin
                r_sba[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_sba[0].valid <= i_s_axis_tvalid;
            r_sba[0].last  <= i_s_axis_tlast;
            r_sba[0].sat_u <= (DEN_W'(w_u) >= w_ea);
            r_sba[0].sat_v <= (DEN_W'(w_v) >= w_eb);
            for (int k = 1; k < NORM_STEPS; k++) begin
                r_sba[k] <= r_sba[k-1];
            end
        end
    end

    // Stage 1: remove the offset, saturated values become +1.
    always_comb begin
        n_s1_xn = r_sba[NORM_STEPS-1].sat_u ? (N_W'(1) <<< FRAC_BITS)
                : (N_W'(w_nu[NORM_STEPS].quot) - (N_W'(1) <<< FRAC_BITS));
        n_s1_yn = r_sba[NORM_STEPS-1].sat_v ? (N_W'(1) <<< FRAC_BITS)
                : (N_W'(w_nv[NORM_STEPS].quot) - (N_W'(1) <<< FRAC_BITS));
    end

    // Stage 3 decode: pick the major axis and set up the ratio divider.
    always_comb begin
        n_s3_sb.valid = r_s2_valid;
        n_s3_sb.last  = r_s2_last;
        n_s3_sb.neg   = r_s2_neg;
        n_s3_sb.zero  = r_s2_zero;
        n_s3_sb.major = (r_s2_ax > r_s2_ay);
        w_num         = n_s3_sb.major ? r_s2_ay : r_s2_ax;
        w_den         = n_s3_sb.major ? r_s2_ax : r_s2_ay;
        n_s3_sb.lead  = n_s3_sb.major ? r_s2_xn : r_s2_yn;
        n_s3_div.den  = DEN_W'(w_den);
        // Equal operands give a ratio of exactly one.
        if (w_num == w_den) begin
            n_s3_div.rem  = '0;
            n_s3_div.quot = Q_W'(1);
        end else begin
            n_s3_div.rem  = DEN_W'(w_num);
            n_s3_div.quot = '0;
        end
    end

    // Setup stages 1 to 3.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_s2_valid      <= 1'b0;
            r_s3_sb.valid   <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= r_sba[NORM_STEPS-1].valid;
            r_s1_last  <= r_sba[NORM_STEPS-1].last;
            r_s1_xn    <= n_s1_xn;
            r_s1_yn    <= n_s1_yn;

            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
            r_s2_xn    <= r_s1_xn;
            r_s2_yn    <= r_s1_yn;
            r_s2_ax    <= r_s1_xn[N_W-1] ? MAG_W'(-r_s1_xn) : MAG_W'(r_s1_xn);
            r_s2_ay    <= r_s1_yn[N_W-1] ? MAG_W'(-r_s1_yn) : MAG_W'(r_s1_yn);
            r_s2_neg   <= r_s1_xn[N_W-1] ^ r_s1_yn[N_W-1];
            r_s2_zero  <= (r_s1_xn == '0) && (r_s1_yn == '0);

            r_s3_sb    <= n_s3_sb;
            r_s3_div   <= n_s3_div;
        end
    end

    // Ratio divider: minor / major in Q(F), one bit per cell.
    assign w_rt[0] = r_s3_div;

    for (genvar k = 0; k < RATIO_STEPS; k++) begin : g_ratio
        cdw_div_cell u_cell (.i_clk(i_clk), .i_en(w_en), .i_d(w_rt[k]), .o_d(w_rt[k+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RATIO_STEPS; k++) begin
                r_sbb[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_sbb[0] <= r_s3_sb;
            for (int k = 1; k < RATIO_STEPS; k++) begin
                r_sbb[k] <= r_sbb[k-1];
            end
        end
    end

    // Stage T1: angle and radius products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_sb.valid <= 1'b0;
        end else if (w_en) begin
            r_t1_sb  <= r_sbb[RATIO_STEPS-1];
            r_t1_pth <= PT_W'(PI4_Q30) * PT_W'(w_rt[RATIO_STEPS].quot);
            r_t1_pr  <= PR_W'(r_sbb[RATIO_STEPS-1].lead)
                      * signed'(PR_W'({1'b0, r_radius}));
        end
    end

    // Stage T2: signed angle and rounded radius feed the CORDIC.
    always_comb begin
        w_mag = signed'(ANG_W'(r_t1_pth[FRAC_BITS+TH_W-1:FRAC_BITS]));
        w_rs  = r_t1_pr + (PR_W'(1) <<< (FRAC_BITS - 1));
    end

    // The sideband has one entry more than the CORDIC cells, since the
    // rotation input register sits beside its first entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                r_sbc[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_sbc[0].valid <= r_t1_sb.valid;
            r_sbc[0].last  <= r_t1_sb.last;
            r_sbc[0].major <= r_t1_sb.major;
            r_sbc[0].zero  <= r_t1_sb.zero;
            r_sbc[0].r     <= w_rs[FRAC_BITS+R_W-1:FRAC_BITS];
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                r_sbc[k] <= r_sbc[k-1];
            end
        end
    end

    t_cor r_cor_in;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cor_in.x <= signed'(GAIN_INV_Q30);
            r_cor_in.y <= '0;
            r_cor_in.z <= r_t1_sb.neg ? -w_mag : w_mag;
        end
    end

    // CORDIC rotation cells.
    assign w_cor[0] = r_cor_in;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        cdw_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (STG_W'(k)),
            .i_d     (w_cor[k]),
            .o_d     (w_cor[k+1])
        );
    end

    // Stage M1: scale cos and sin by the radius; swap when y is major.
    assign w_tx = r_sbc[CORDIC_STAGES].major ? w_cor[CORDIC_STAGES].x
                                             : w_cor[CORDIC_STAGES].y;
    assign w_ty = r_sbc[CORDIC_STAGES].major ? w_cor[CORDIC_STAGES].y
                                             : w_cor[CORDIC_STAGES].x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= r_sbc[CORDIC_STAGES].valid;
            r_m1_last  <= r_sbc[CORDIC_STAGES].last;
            r_m1_zero  <= r_sbc[CORDIC_STAGES].zero;
            r_m1_px    <= PO_W'(r_sbc[CORDIC_STAGES].r) * PO_W'(w_tx);
            r_m1_py    <= PO_W'(r_sbc[CORDIC_STAGES].r) * PO_W'(w_ty);
        end
    end

    // Output register: the centre maps to the origin.
    always_comb begin
        n_o_x = r_m1_zero ? '0 : round_sat(r_m1_px);
        n_o_y = r_m1_zero ? '0 : round_sat(r_m1_py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_m1_valid;
            r_o_last  <= r_m1_last;
            r_o_x     <= n_o_x;
            r_o_y     <= n_o_y;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 2*OUT_W)'(0), r_o_y, r_o_x};

endmodule

// ----- sv/cdw_div_cell.sv -----
// One registered restoring-division step: produces one quotient bit.
module cdw_div_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  cdw_pkg::t_div  i_d,
    output cdw_pkg::t_div  o_d
);
    import cdw_pkg::*;

    logic [DEN_W:0] w_rem2;
    logic           w_ge;
    t_div           n_d;
    t_div           r_d;

    // Shift the remainder and subtract the divisor where it fits.
    always_comb begin
        w_rem2    = {i_d.rem, 1'b0};
        w_ge      = (w_rem2 >= {1'b0, i_d.den});
        n_d.den   = i_d.den;
        n_d.quot  = {i_d.quot[Q_W-2:0], w_ge};
        n_d.rem   = w_ge ? DEN_W'(w_rem2 - {1'b0, i_d.den}) : w_rem2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- sv/cdw_cordic_cell.sv -----
// One registered CORDIC rotation stage.
module cdw_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [cdw_pkg::STG_W-1:0]  i_stage,
    input  cdw_pkg::t_cor              i_d,
    output cdw_pkg::t_cor              o_d
);
    import cdw_pkg::*;

    logic signed [CW-1:0]    w_dx;
    logic signed [CW-1:0]    w_dy;
    logic signed [ANG_W-1:0] w_at;
    t_cor                    n_d;
    t_cor                    r_d;

    // Rotate toward zero residual angle.
    always_comb begin
        w_dx = i_d.y >>> i_stage;
        w_dy = i_d.x >>> i_stage;
        w_at = signed'(cdw_atan(i_stage));
        if (!i_d.z[ANG_W-1]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - w_at;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- tb/concentric_disk_warp_checker.sv -----
// Checker for the disk warp: predicts every disk point and compares the output stream.
module concentric_disk_warp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cdw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cdw_pkg::EXT_W-1:0]         i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    // u_coord [15:0], v_coord [31:16]
    input  logic [cdw_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // x_out [16:0], y_out [33:17], zero fill above
    input  logic [cdw_pkg::OUT_TDATA_W-1:0]   i_m_axis_tdata,
    input  logic                              i_m_axis_tlast,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_checked
);
    import cdw_pkg::*;

    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             last;
    } t_disk_point;

    // Arctangent of 2^-i in Q30 radians.
    localparam longint ARCTAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };
    localparam longint QUARTER_PI_Q30 = 843314857;
    localparam longint CORDIC_GAIN_Q30 = 652032874;
    localparam longint SAT_LIMIT = 65535;

    logic [EXT_W-1:0] width_reg;
    logic [EXT_W-1:0] height_reg;
    logic [RAD_W-1:0] radius_reg;
    t_disk_point      expected_points [$];

    // Map a coordinate onto [-1, 1] in Q16, clamping at the extent.
    function automatic longint norm_coord(input longint c, input longint ext);
        longint e;
        longint q;
        e = (ext == 0) ? 1 : ext;
        q = (c << (FRAC_BITS + 1)) / e;
        if (q > (longint'(2) << FRAC_BITS)) q = longint'(2) << FRAC_BITS;
        return q - (longint'(1) << FRAC_BITS);
    endfunction

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint scale_sat(input longint r, input longint trig);
        longint v;
        v = round_half_up(r * trig, 30);
        if (v > SAT_LIMIT) v = SAT_LIMIT;
        if (v < -SAT_LIMIT) v = -SAT_LIMIT;
        return v;
    endfunction

    // Work out the disk point of one sample under the current registers.
    function automatic t_disk_point warp_point(input logic [15:0] u, input logic [15:0] v,
                                               input logic last);
        t_disk_point p;
        longint xn, yn, ax, ay, num, den, lead, t, theta, r, cx, sy, zr, dx, dy;
        bit     major_x, neg;
        longint xo, yo;
        xn = norm_coord(longint'(u), longint'(width_reg));
        yn = norm_coord(longint'(v), longint'(height_reg));
        xo = 0;
        yo = 0;
        if (xn != 0 || yn != 0) begin
            ax = (xn < 0) ? -xn : xn;
            ay = (yn < 0) ? -yn : yn;
            major_x = ax > ay;
            num = major_x ? ay : ax;
            den = major_x ? ax : ay;
            lead = major_x ? xn : yn;
            neg = (xn < 0) != (yn < 0);
            t = (num << FRAC_BITS) / den;
            theta = (QUARTER_PI_Q30 * t) >> FRAC_BITS;
            r = round_half_up(lead * longint'(radius_reg), FRAC_BITS);
            if (neg) theta = -theta;
            // Rotation from (K, 0) towards theta.
            cx = CORDIC_GAIN_Q30;
            sy = 0;
            zr = theta;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
                dx = sy >>> i;
                dy = cx >>> i;
                if (zr >= 0) begin
                    cx -= dx; sy += dy; zr -= ARCTAN_Q30[i];
                end else begin
                    cx += dx; sy -= dy; zr += ARCTAN_Q30[i];
                end
            end
            if (major_x) begin
                xo = scale_sat(r, cx);
                yo = scale_sat(r, sy);
            end else begin
                xo = scale_sat(r, sy);
                yo = scale_sat(r, cx);
            end
        end
        p.x = xo[OUT_W-1:0];
        p.y = yo[OUT_W-1:0];
        p.last = last;
        return p;
    endfunction

    // Track register writes, predict accepted samples, check each output transfer.
    always @(posedge i_clk) begin
        t_disk_point exp_pt;
        logic [OUT_W-1:0] got_x;
        logic [OUT_W-1:0] got_y;
        if (!i_rst_n) begin
            width_reg <= 16'd65535;
            height_reg <= 16'd65535;
            radius_reg <= 16'd256;
            expected_points.delete();
            o_mismatches <= 0;
            o_checked <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_points.push_back(warp_point(i_s_axis_tdata[15:0],
                                                     i_s_axis_tdata[31:16], i_s_axis_tlast));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_x = i_m_axis_tdata[OUT_W-1:0];
                got_y = i_m_axis_tdata[2*OUT_W-1:OUT_W];
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected output x=%0d y=%0d last=%0b", $time,
                             $signed(got_x), $signed(got_y), i_m_axis_tlast);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    exp_pt = expected_points.pop_front();
                    o_checked <= o_checked + 1;
                    if (got_x !== exp_pt.x || got_y !== exp_pt.y ||
                        i_m_axis_tlast !== exp_pt.last ||
                        i_m_axis_tdata[OUT_TDATA_W-1:2*OUT_W] !== '0) begin
                        $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 $time, $signed(exp_pt.x), $signed(exp_pt.y), exp_pt.last,
                                 $signed(got_x), $signed(got_y), i_m_axis_tlast);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            o_pending <= expected_points.size();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_A_EXTENT: width_reg <= i_cfg_data;
                    CFG_B_EXTENT: height_reg <= i_cfg_data;
                    CFG_RADIUS:   radius_reg <= i_cfg_data;
                    default:      ;
                endcase
            end
        end
    end

endmodule

// ----- tb/concentric_disk_warp_top_test.sv -----
// Testbench top for the disk warp: clock, reset, stimulus, stalls and verdict.
module concentric_disk_warp_top_test;
    import cdw_pkg::*;

    localparam int PIPE_DEPTH = 55;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_idx;
    logic [EXT_W-1:0]          cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_W-1:0]     s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_W-1:0]    m_tdata;
    logic                      m_tlast;
    int                        mismatches;
    int                        pending;
    int                        checked;
    int                        samples_sent;
    int                        burst_left;
    logic [EXT_W-1:0]          cur_width;
    logic [EXT_W-1:0]          cur_height;

    concentric_disk_warp_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast)
    );

    concentric_disk_warp_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tlast(m_tlast),
        .o_mismatches(mismatches), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver stalls: one of four patterns, picked at random and changed periodically.
    initial begin
        int stall_mode;
        int cyc;
        m_tready = 1'b0;
        stall_mode = 0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 250 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ((cyc % 13) < 9);
            endcase
            cyc++;
        end
    end

    // Register write, only issued with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EXT_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 5) @(negedge i_clk);
    endtask

    task automatic set_rect(input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h,
                            input logic [RAD_W-1:0] rad);
        drain();
        write_reg(CFG_A_EXTENT, w);
        write_reg(CFG_B_EXTENT, h);
        write_reg(CFG_RADIUS, rad);
        cur_width = w;
        cur_height = h;
    endtask

    // One sample transfer; valid stays high inside a burst.
    task automatic send_sample(input logic [15:0] u, input logic [15:0] v, input logic last);
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, u};
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        samples_sent++;
    endtask

    // Pick a coordinate mostly inside the extent, sometimes at or beyond it.
    function automatic logic [15:0] pick_coord(input logic [EXT_W-1:0] ext);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return ext;
        if (sel == 2) return (ext == 0) ? 16'd0 : ext - 16'd1;
        if (sel == 3) return ext >> 1;
        return (ext <= 1) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(0, ext - 1));
    endfunction

    task automatic random_samples(input int count);
        repeat (count)
            send_sample(pick_coord(cur_width), pick_coord(cur_height),
                        1'($urandom_range(0, 1)));
    endtask

    initial begin
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        samples_sent = 0;
        burst_left = 0;
        cur_width = 16'd65535;
        cur_height = 16'd65535;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: corners, centre, saturation, all with the reset registers.
        send_sample(16'd0, 16'd0, 1'b0);
        send_sample(16'd65535, 16'd65535, 1'b1);
        send_sample(16'd0, 16'd65535, 1'b0);
        send_sample(16'd65535, 16'd0, 1'b1);
        send_sample(16'd32767, 16'd32767, 1'b0);
        send_sample(16'd32768, 16'd32768, 1'b0);
        send_sample(16'd40000, 16'd32768, 1'b1);
        send_sample(16'd32768, 16'd50000, 1'b0);
        // Tiny extents and the largest radius; centre exactly hit with extent 2.
        set_rect(16'd2, 16'd2, 16'd65535);
        send_sample(16'd1, 16'd1, 1'b1);
        send_sample(16'd0, 16'd1, 1'b0);
        send_sample(16'd5, 16'd0, 1'b1);
        send_sample(16'd65535, 16'd65535, 1'b0);
        // Zero extents act as one; zero radius; a write to the unused index.
        set_rect(16'd0, 16'd0, 16'd0);
        write_reg(2'd3, 16'hFFFF);
        send_sample(16'd0, 16'd0, 1'b0);
        send_sample(16'd1, 16'd0, 1'b1);
        set_rect(16'd0, 16'd1, 16'd256);
        send_sample(16'd0, 16'd1, 1'b0);
        send_sample(16'd1, 16'd0, 1'b1);
        send_sample(16'd0, 16'd0, 1'b0);

        // Random phases over several register settings.
        set_rect(16'd65535, 16'd65535, 16'd256);
        random_samples(75);
        set_rect(16'd1000, 16'd700, 16'd300);
        random_samples(75);
        set_rect(16'd3, 16'd65535, 16'd65535);
        random_samples(60);
        set_rect(16'd1, 16'd1, 16'd1);
        random_samples(30);
        repeat (3) begin
            set_rect(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                     16'($urandom));
            random_samples(70);
        end

        drain();
        repeat (5) @(negedge i_clk);
        $display("Sent %0d samples over ten register settings; %0d disk points checked.",
                 samples_sent, checked);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
